>>> sv/spwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spwm_pkg;

  // Default configuration of the timer
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int COUNT_WIDTH_DEF  = 16;

  // Field widths of the request and result items
  localparam int CHAN_W  = 8;
  localparam int PULSE_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 4;

  // Register reset values
  localparam logic [CFG_W-1:0]   PRESCALE_RST = 16'd83;
  localparam logic [CFG_W-1:0]   PERIOD_RST   = 16'd19999;
  localparam logic [CFG_W-1:0]   FLOOR_RST    = 16'd1000;
  localparam logic [CFG_W-1:0]   CEIL_RST     = 16'd2000;
  localparam logic [PULSE_W-1:0] PULSE_RST    = 16'd1500;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL     = 4'd3;

  // Request commands
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_GET  = 2'd2
  } cmd_e;

  // One request as held in the input register
  typedef struct packed {
    cmd_e               cmd;
    logic [CHAN_W-1:0]  channel;
    logic [PULSE_W-1:0] pulse_req;
  } req_t;

  // Status flags of one result
  typedef struct packed {
    logic accepted;
    logic update_event;
  } res_flags_t;

  // Handshake between the input register and the result register
  typedef struct packed {
    logic advance;   // request moves from input register into result register
  } stage_ctrl_t;

endpackage

`default_nettype wire

>>> sv/spwm_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module spwm_in_stage
  import spwm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire req_t        s_req_i,
  input  wire logic        out_ready_i,
  output stage_ctrl_t      ctrl_o,
  output req_t             req_o
);

  logic valid_q, valid_d;
  req_t req_q;
  logic advance;

  // Move the held request on when the result register has room
  assign advance   = valid_q && out_ready_i;
  assign s_ready_o = !valid_q || advance;

  assign ctrl_o.advance   = advance;
  assign req_o            = req_q;

  // Track occupancy of the input register
  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      req_q <= s_req_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/spwm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module spwm_core
  import spwm_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i,
  input  wire stage_ctrl_t             ctrl_i,
  input  wire req_t                    req_i,
  output logic [NUM_CHANNELS-1:0]      pwm_o,
  output logic [PULSE_W-1:0]           read_pulse_o,
  output res_flags_t                   flags_o
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CMP_W = (COUNT_WIDTH > PULSE_W) ? COUNT_WIDTH : PULSE_W;
  localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(NUM_CHANNELS);

  // Configuration registers
  logic [CFG_W-1:0] prescale_limit_q, period_limit_q, pulse_floor_q, pulse_ceiling_q;

  // Timer state
  logic [CFG_W-1:0]       prescale_count_q, prescale_count_d;
  logic [COUNT_WIDTH-1:0] period_count_q, period_count_d;
  logic [PULSE_W-1:0]     preload_q [NUM_CHANNELS];
  logic [PULSE_W-1:0]     active_q  [NUM_CHANNELS];
  logic [PULSE_W-1:0]     active_d  [NUM_CHANNELS];

  logic [COUNT_WIDTH-1:0] period_lim_cut;
  logic [IDX_W-1:0]       chan_idx;
  logic                   chan_ok;
  logic                   upd;
  logic                   set_we;
  logic [PULSE_W-1:0]     clamped;

  assign period_lim_cut = COUNT_WIDTH'(period_limit_q);
  assign chan_idx       = IDX_W'(req_i.channel - CHAN_W'(1));
  assign chan_ok        = (req_i.channel != '0) && (req_i.channel <= CHAN_LAST);

  // Clamp the requested pulse, floor taking priority
  always_comb begin
    if (req_i.pulse_req < pulse_floor_q) begin
      clamped = pulse_floor_q;
    end else if (req_i.pulse_req > pulse_ceiling_q) begin
      clamped = pulse_ceiling_q;
    end else begin
      clamped = req_i.pulse_req;
    end
  end

  // Advance prescaler and period counter on a tick
  always_comb begin
    prescale_count_d = prescale_count_q;
    period_count_d   = period_count_q;
    upd              = 1'b0;
    if (req_i.cmd == CMD_TICK) begin
      if (prescale_count_q >= prescale_limit_q) begin
        prescale_count_d = '0;
        if (period_count_q >= period_lim_cut) begin
          period_count_d = '0;
          upd            = 1'b1;
        end else begin
          period_count_d = period_count_q + COUNT_WIDTH'(1);
        end
      end else begin
        prescale_count_d = prescale_count_q + CFG_W'(1);
      end
    end
  end

  assign set_we = (req_i.cmd == CMD_SET) && chan_ok;

  // Copy preloads into active compares on the update event, build outputs
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      active_d[i] = upd ? preload_q[i] : active_q[i];
      pwm_o[i]    = CMP_W'(period_count_d) < CMP_W'(active_d[i]);
    end
  end

  // Result fields other than the outputs
  always_comb begin
    read_pulse_o         = '0;
    flags_o.accepted     = 1'b0;
    flags_o.update_event = upd;
    case (req_i.cmd)
      CMD_TICK: flags_o.accepted = 1'b0;
      CMD_SET:  flags_o.accepted = chan_ok;
      CMD_GET: begin
        flags_o.accepted = chan_ok;
        if (chan_ok) begin
          read_pulse_o = preload_q[chan_idx];
        end
      end
      default: flags_o.accepted = 1'b0;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_limit_q <= PRESCALE_RST;
      period_limit_q   <= PERIOD_RST;
      pulse_floor_q    <= FLOOR_RST;
      pulse_ceiling_q  <= CEIL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRESCALE: prescale_limit_q <= cfg_data_i;
        CFG_PERIOD:   period_limit_q   <= cfg_data_i;
        CFG_FLOOR:    pulse_floor_q    <= cfg_data_i;
        CFG_CEIL:     pulse_ceiling_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Commit timer state when a request moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_count_q <= '0;
      period_count_q   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        preload_q[i] <= PULSE_RST;
        active_q[i]  <= PULSE_RST;
      end
    end else if (ctrl_i.advance) begin
      prescale_count_q <= prescale_count_d;
      period_count_q   <= period_count_d;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        active_q[i] <= active_d[i];
      end
      if (set_we) begin
        preload_q[chan_idx] <= clamped;
      end
    end
  end

  // An update event leaves both counters at zero
  a_upd_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.advance && flags_o.update_event |=>
      (period_count_q == '0) && (prescale_count_q == '0))
    else $error("counters not cleared after update event");

  // Every request other than a tick leaves the counters alone
  a_cmd_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.advance && (req_i.cmd != CMD_TICK) |=>
      $stable(period_count_q) && $stable(prescale_count_q))
    else $error("counter moved on a non-tick request");

  // A stored pulse is the floor, the ceiling, or lies between them
  a_set_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.advance && set_we |->
      (clamped == pulse_floor_q) || (clamped == pulse_ceiling_q) ||
      ((clamped >= pulse_floor_q) && (clamped <= pulse_ceiling_q)))
    else $error("stored pulse outside limits");

  // Only a tick can raise the update flag, never together with accepted
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.advance |-> !(flags_o.accepted && flags_o.update_event))
    else $error("accepted and update event both set");

endmodule

`default_nettype wire

>>> sv/spwm_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module spwm_out_stage
  import spwm_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire logic [NUM_CHANNELS-1:0] pwm_i,
  input  wire logic [PULSE_W-1:0]      read_pulse_i,
  input  wire res_flags_t              flags_i,
  output logic                         ready_o,
  output logic                         m_valid_o,
  input  wire logic                    m_ready_i,
  output logic [NUM_CHANNELS-1:0]      pwm_o,
  output logic [PULSE_W-1:0]           read_pulse_o,
  output res_flags_t                   flags_o
);

  logic                    valid_q, valid_d;
  logic [NUM_CHANNELS-1:0] pwm_q;
  logic [PULSE_W-1:0]      read_pulse_q;
  res_flags_t              flags_q;

  // Room when empty or when the held result is taken now
  assign ready_o      = !valid_q || m_ready_i;
  assign m_valid_o    = valid_q;
  assign pwm_o        = pwm_q;
  assign read_pulse_o = read_pulse_q;
  assign flags_o      = flags_q;

  // Track occupancy of the result register
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pwm_q        <= pwm_i;
      read_pulse_q <= read_pulse_i;
      flags_q      <= flags_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/four_channel_servo_pwm_timer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Servo / ESC PWM timer with one request stream in and one result stream out.
// Requests on s_axis: tuser carries the command (tick, set pulse, read pulse),
// tdata the channel number and the requested pulse width. Every request gives
// exactly one result on m_axis: channel outputs after the request, the preload
// read back, an accepted flag and the update event flag of a wrapping tick.
// Registers (prescale limit, period limit, pulse floor, pulse ceiling) are
// written over the cfg channel, which is always ready; write them only while
// no request is in flight.
// The request passes through the input register and then the result register, which
// drives m_axis; a stall on m_axis can hold the request in the input register.
// Throughput: one request per cycle while m_axis does not stall; the counters,
// compares and clamp all settle between those two registers.
// When m_axis stalls, the result register holds and s_axis_tready drops once
// the input register is full as well.
// Reset clears both registers and counters, loads the register defaults and
// sets every preload and active compare to 1500.
module four_channel_servo_pwm_timer_unit
  import spwm_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // request stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [23:0]          s_axis_tdata,  // channel[7:0], pulse_req[23:8]
  input  wire logic [1:0]           s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // pwm_out, read_pulse, accepted, update_event from bit 0 up, zero padded
  output logic [((NUM_CHANNELS + PULSE_W + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int OUT_W = ((NUM_CHANNELS + PULSE_W + 2 + 7) / 8) * 8;

  req_t                    s_req;
  req_t                    req;
  stage_ctrl_t             ctrl;
  logic                    out_ready;
  logic [NUM_CHANNELS-1:0] core_pwm, out_pwm;
  logic [PULSE_W-1:0]      core_rd, out_rd;
  res_flags_t              core_flags, out_flags;

  assign cfg_ready_o       = 1'b1;
  assign s_req.cmd         = cmd_e'(s_axis_tuser);
  assign s_req.channel     = s_axis_tdata[CHAN_W-1:0];
  assign s_req.pulse_req   = s_axis_tdata[CHAN_W +: PULSE_W];

  spwm_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_req_i     (s_req),
    .out_ready_i (out_ready),
    .ctrl_o      (ctrl),
    .req_o       (req)
  );

  spwm_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .ctrl_i       (ctrl),
    .req_i        (req),
    .pwm_o        (core_pwm),
    .read_pulse_o (core_rd),
    .flags_o      (core_flags)
  );

  spwm_out_stage #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (ctrl.advance),
    .pwm_i        (core_pwm),
    .read_pulse_i (core_rd),
    .flags_i      (core_flags),
    .ready_o      (out_ready),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .pwm_o        (out_pwm),
    .read_pulse_o (out_rd),
    .flags_o      (out_flags)
  );

  // Pack the result, first field in the lowest bits
  assign m_axis_tdata = OUT_W'({out_flags.update_event, out_flags.accepted, out_rd, out_pwm});

endmodule

`default_nettype wire

>>> test/four_channel_servo_pwm_timer_unit_tb.sv
`timescale 1ns / 1ps

module four_channel_servo_pwm_timer_unit_tb;
  import spwm_pkg::*;

  localparam int NUM_CH = NUM_CHANNELS_DEF;
  localparam int RES_W = ((NUM_CH + PULSE_W + 2 + 7) / 8) * 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 250;

  // One result as packed on m_axis_tdata, lowest field last
  typedef struct packed {
    logic               update_event;
    logic               accepted;
    logic [PULSE_W-1:0] read_pulse;
    logic [NUM_CH-1:0]  pwm_out;
  } timer_result_t;

  // Shadow timer: tracks counters and compares, queues the result of each request
  class servo_timer_scoreboard;
    logic [CFG_W-1:0]           prescale_limit;
    logic [CFG_W-1:0]           period_limit;
    logic [CFG_W-1:0]           pulse_floor;
    logic [CFG_W-1:0]           pulse_ceiling;
    logic [CFG_W-1:0]           prescale_count;
    logic [COUNT_WIDTH_DEF-1:0] period_count;
    logic [PULSE_W-1:0]         preload_cmp[NUM_CH];
    logic [PULSE_W-1:0]         active_cmp[NUM_CH];
    timer_result_t              expected_results[$];
    int                         failures;

    function new();
      prescale_limit = PRESCALE_RST;
      period_limit   = PERIOD_RST;
      pulse_floor    = FLOOR_RST;
      pulse_ceiling  = CEIL_RST;
      prescale_count = '0;
      period_count   = '0;
      foreach (preload_cmp[i]) begin
        preload_cmp[i] = PULSE_RST;
        active_cmp[i]  = PULSE_RST;
      end
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_PRESCALE: prescale_limit = val;
        CFG_PERIOD:   period_limit = val;
        CFG_FLOOR:    pulse_floor = val;
        CFG_CEIL:     pulse_ceiling = val;
        default: ;
      endcase
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(logic [1:0] cmd, logic [CHAN_W-1:0] chan,
                               logic [PULSE_W-1:0] pw);
      timer_result_t res;
      logic          chan_ok;
      int            slot;
      res     = '0;
      chan_ok = (chan >= 1) && (chan <= NUM_CH);
      slot    = int'(chan) - 1;
      case (cmd)
        CMD_TICK: begin
          if (prescale_count >= prescale_limit) begin
            prescale_count = '0;
            // wrap of the period is the update event: load the active compares
            if (period_count >= period_limit) begin
              period_count     = '0;
              res.update_event = 1'b1;
              foreach (active_cmp[i]) active_cmp[i] = preload_cmp[i];
            end else begin
              period_count = period_count + 1'b1;
            end
          end else begin
            prescale_count = prescale_count + 1'b1;
          end
        end
        CMD_SET: begin
          if (chan_ok) begin
            // floor wins over ceiling for a pulse below the floor, even when floor > ceiling
            if (pw < pulse_floor) preload_cmp[slot] = pulse_floor;
            else if (pw > pulse_ceiling) preload_cmp[slot] = pulse_ceiling;
            else preload_cmp[slot] = pw;
            res.accepted = 1'b1;
          end
        end
        CMD_GET: begin
          if (chan_ok) begin
            res.read_pulse = preload_cmp[slot];
            res.accepted   = 1'b1;
          end
        end
        default: ;
      endcase
      for (int i = 0; i < NUM_CH; i++) res.pwm_out[i] = period_count < active_cmp[i];
      expected_results.push_back(res);
    endfunction

    function void mismatch(string what, longint unsigned want, longint unsigned got);
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(logic [RES_W-1:0] data);
      timer_result_t got;
      timer_result_t want;
      got = data[$bits(timer_result_t)-1:0];
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: result with no request, expected none, actual %0h", $time, data);
      end else begin
        want = expected_results.pop_front();
        if (got.pwm_out !== want.pwm_out) mismatch("pwm_out", want.pwm_out, got.pwm_out);
        if (got.read_pulse !== want.read_pulse)
          mismatch("read_pulse", want.read_pulse, got.read_pulse);
        if (got.accepted !== want.accepted)
          mismatch("accepted", want.accepted, got.accepted);
        if (got.update_event !== want.update_event)
          mismatch("update_event", want.update_event, got.update_event);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata;   // channel[7:0], pulse_req[23:8]
  logic [1:0]         s_axis_tuser;   // cmd[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [RES_W-1:0]   m_axis_tdata;   // pwm_out, read_pulse, accepted, update_event
  logic               steady;

  servo_timer_scoreboard sb = new();

  four_channel_servo_pwm_timer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Drain results, stalling at random outside the steady stretch
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= !(!steady && ($urandom_range(0, 99) < 8));
    end
  end

  // Send one request, idling at random first, and wait for its handshake
  task automatic send_request(input logic [1:0] cmd, input logic [CHAN_W-1:0] chan,
                              input logic [PULSE_W-1:0] pw);
    while (!steady && ($urandom_range(0, 99) < 8)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {pw, chan};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, chan, pw);
  endtask

  // Write one register; the caller drops cfg_valid_i after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  // Quiesce, reprogram all registers, then stream random requests
  task automatic run_phase(input logic [CFG_W-1:0] pre, input logic [CFG_W-1:0] per,
                           input logic [CFG_W-1:0] flo, input logic [CFG_W-1:0] cei,
                           input logic quiet);
    int                 hi;
    int                 pick;
    logic [1:0]         cmd;
    logic [CHAN_W-1:0]  chan;
    logic [PULSE_W-1:0] pw;
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    steady = quiet;
    write_reg(CFG_PRESCALE, pre);
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_FLOOR, flo);
    write_reg(CFG_CEIL, cei);
    cfg_valid_i <= 1'b0;
    // keep most pulses near the clamp window so outputs and clamps both move
    hi = (flo > cei) ? int'(flo) : int'(cei);
    hi = (hi + 8 > 65535) ? 65535 : hi + 8;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) cmd = CMD_TICK;
      else if (pick < 77) cmd = CMD_SET;
      else if (pick < 97) cmd = CMD_GET;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 99) < 88) chan = CHAN_W'($urandom_range(1, NUM_CH));
      else chan = CHAN_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pw = PULSE_W'($urandom_range(0, hi));
      end else if (pick < 85) begin
        pw = PULSE_W'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: pw = '0;
          1: pw = '1;
          2: pw = flo;
          default: pw = cei;
        endcase
      end
      send_request(cmd, chan, pw);
    end
  endtask

  // Main sequence
  initial begin
    int n;
    steady        = 1'b0;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset values, clamping, bad channels, unused command, ticks
    for (n = 1; n <= NUM_CH; n++) send_request(CMD_GET, CHAN_W'(n), '0);
    send_request(CMD_SET, 8'd1, 16'h0000);
    send_request(CMD_SET, 8'd2, 16'hFFFF);
    send_request(CMD_SET, 8'd3, 16'd1234);
    send_request(CMD_SET, 8'd4, CEIL_RST);
    send_request(CMD_SET, 8'd0, 16'd1500);
    send_request(CMD_SET, 8'd5, 16'd1700);
    send_request(CMD_SET, 8'd255, 16'hFFFF);
    send_request(CMD_GET, 8'd0, 16'hFFFF);
    send_request(CMD_GET, 8'd5, '0);
    send_request(CMD_GET, 8'd255, '0);
    send_request(CMD_UNUSED, 8'd1, 16'hFFFF);
    for (n = 1; n <= NUM_CH; n++) send_request(CMD_GET, CHAN_W'(n), '0);
    repeat (5) send_request(CMD_TICK, 8'd0, '0);

    // Random phases over a spread of register settings
    run_phase(16'd0, 16'd15, 16'd2, 16'd12, 1'b0);
    run_phase(16'd2, 16'd40, 16'd0, 16'd41, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
    run_phase(16'd0, 16'd0, 16'd50000, 16'd10, 1'b0);
    run_phase(16'd1, 16'd25, 16'd5, 16'd20, 1'b1);
    run_phase(16'd0, 16'd7, 16'd0, 16'd8, 1'b0);
    run_phase(CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 60)),
              CFG_W'($urandom_range(0, 70)), CFG_W'($urandom_range(0, 70)), 1'b0);
    run_phase(16'd3, 16'd100, 16'd10, 16'd90, 1'b0);

    // Wait for the last results, bounded
    s_axis_tvalid <= 1'b0;
    for (n = 0; n < 1000 && sb.expected_results.size() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.expected_results.size());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/spwm_pkg.sv
sv/spwm_in_stage.sv
sv/spwm_core.sv
sv/spwm_out_stage.sv
sv/four_channel_servo_pwm_timer_unit.sv
test/four_channel_servo_pwm_timer_unit_tb.sv
